FILE: sv/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bpc_pkg.sv
// Types and constants shared by the button press classifier modules.
package bpc_pkg;

  localparam int MaxKeys = 5;
  localparam int PhaseW  = 3;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SHORT    = 3'd3,
    PH_LONG     = 3'd4,
    PH_DOUBLE   = 3'd5,
    PH_WAIT     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CFG_LONG_PRESS    = 2'd0,
    CFG_DOUBLE_WINDOW = 2'd1,
    CFG_STUCK_TIMEOUT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] double_click_window_ms;
    logic [15:0] stuck_timeout_ms;
  } cfg_t;

  localparam logic [15:0] LONG_PRESS_RST    = 16'd1000;
  localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd500;
  localparam logic [15:0] STUCK_TIMEOUT_RST = 16'd5000;

endpackage

FILE: sv/bpc_key.sv
// One key's state machine with its press and release timestamps.
module bpc_key (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            down,
  input  logic [31:0]     now_ms,
  input  bpc_pkg::cfg_t   cfg,
  output bpc_pkg::phase_t phase_next
);

  bpc_pkg::phase_t phase;
  logic [31:0]     press_time;
  logic [31:0]     release_time;
  logic [31:0]     held;
  logic [31:0]     since_rel;

  // Elapsed times wrap modulo 2^32 along with the tick counter.
  assign held      = now_ms - press_time;
  assign since_rel = now_ms - release_time;

  always_comb begin
    case (phase)
      bpc_pkg::PH_IDLE: begin
        phase_next = down ? bpc_pkg::PH_PRESSED : bpc_pkg::PH_IDLE;
      end
      bpc_pkg::PH_PRESSED: begin
        if (!down) begin
          phase_next = bpc_pkg::PH_RELEASED;
        end else if (held > {16'd0, cfg.long_press_ms}) begin
          phase_next = bpc_pkg::PH_LONG;
        end else if (held > {16'd0, cfg.stuck_timeout_ms}) begin
          phase_next = bpc_pkg::PH_IDLE;
        end else begin
          phase_next = bpc_pkg::PH_PRESSED;
        end
      end
      bpc_pkg::PH_RELEASED: begin
        // A press exactly at the window edge is neither double nor short.
        if (down && (since_rel < {16'd0, cfg.double_click_window_ms})) begin
          phase_next = bpc_pkg::PH_DOUBLE;
        end else if (since_rel > {16'd0, cfg.double_click_window_ms}) begin
          phase_next = bpc_pkg::PH_SHORT;
        end else if (since_rel > {16'd0, cfg.stuck_timeout_ms}) begin
          phase_next = bpc_pkg::PH_IDLE;
        end else begin
          phase_next = bpc_pkg::PH_RELEASED;
        end
      end
      bpc_pkg::PH_SHORT, bpc_pkg::PH_LONG, bpc_pkg::PH_DOUBLE: begin
        phase_next = bpc_pkg::PH_WAIT;
      end
      bpc_pkg::PH_WAIT: begin
        phase_next = down ? bpc_pkg::PH_WAIT : bpc_pkg::PH_IDLE;
      end
      default: begin
        phase_next = bpc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bpc_pkg::PH_IDLE;
    end else if (en) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && (phase == bpc_pkg::PH_IDLE) && down) begin
      press_time <= now_ms;
    end
    if (en && (phase == bpc_pkg::PH_PRESSED) && !down) begin
      release_time <= now_ms;
    end
  end

endmodule

FILE: sv/button_press_classifier_top.sv
// A scan is captured in the input register and its key states in the result register.
// Throughput: one scan per cycle while out_ready does not stall the result register;
// the single key-cell stage lies between the input register and the result register.
// Reset: all keys go idle, the thresholds return to 1000, 500 and 5000 ms and
// both registers empty; timestamps are not cleared and there is no clearing pass.
module button_press_classifier_top #(
  parameter int KEY_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  key_levels,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] key_states,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bpc_pkg::cfg_t cfg;
  logic          s1_valid;
  logic [4:0]    s1_levels;
  logic [31:0]   s1_now;
  logic          advance;
  logic          key_en;
  logic [14:0]   states_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms          <= bpc_pkg::LONG_PRESS_RST;
      cfg.double_click_window_ms <= bpc_pkg::DOUBLE_WINDOW_RST;
      cfg.stuck_timeout_ms       <= bpc_pkg::STUCK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (bpc_pkg::cfg_idx_t'(cfg_index))
        bpc_pkg::CFG_LONG_PRESS:    cfg.long_press_ms          <= cfg_data;
        bpc_pkg::CFG_DOUBLE_WINDOW: cfg.double_click_window_ms <= cfg_data;
        bpc_pkg::CFG_STUCK_TIMEOUT: cfg.stuck_timeout_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register frees up when it is empty or its beat is taken.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign key_en   = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_levels <= key_levels;
      s1_now    <= now_ms;
    end
  end

  for (genvar k = 0; k < bpc_pkg::MaxKeys; k++) begin : g_key
    if (k < KEY_COUNT) begin : g_used
      bpc_pkg::phase_t phase_next;

      bpc_key u_key (
        .clk        (clk),
        .rst        (rst),
        .en         (key_en),
        .down       (!s1_levels[k]),
        .now_ms     (s1_now),
        .cfg        (cfg),
        .phase_next (phase_next)
      );

      assign states_next[bpc_pkg::PhaseW*k +: bpc_pkg::PhaseW] = phase_next;
    end else begin : g_unused
      assign states_next[bpc_pkg::PhaseW*k +: bpc_pkg::PhaseW] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_en) begin
      key_states <= states_next;
    end
  end

endmodule

FILE: sv/bpc_checker.sv
// Port-level checks for the button press classifier and their bind.
`include "assert_macros.svh"

module bpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] key_states
);

  logic stalled;
  logic bad_code;

  assign stalled  = out_valid && !out_ready;
  assign bad_code = (key_states[2:0] == 3'b111) || (key_states[5:3] == 3'b111) ||
                    (key_states[8:6] == 3'b111) || (key_states[11:9] == 3'b111) ||
                    (key_states[14:12] == 3'b111);

  `ASSERT_CLK_ALWAYS(a_reset_empties, rst |=> !out_valid, "result beat present after reset")
  `ASSERT_CLK(a_stall_holds, stalled |=> out_valid && $stable(key_states), "stalled beat changed")
  `ASSERT_CLK(a_empty_takes_input, !out_valid |-> in_ready, "input stalled while empty")
  `ASSERT_CLK(a_no_bad_code, out_valid |-> !bad_code, "unused state code reported")

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .key_states (key_states)
);
